// ===== rtl/arg_pkg.sv =====
// Shared constants, codes and types for the address run grouper.
`default_nettype none
package arg_pkg;

  localparam int MAX_ADDRESSES = 64;
  localparam int ADDR_W        = 16;
  localparam int LEN_W         = 7;
  localparam int STATUS_W      = 2;
  localparam int LIMIT_W       = 7;
  localparam int CFG_DATA_W    = 8;
  localparam int REG_IDX_W     = 2;
  localparam int RESULT_CAP    = 64;

  localparam int CNT_W = $clog2(MAX_ADDRESSES + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // queue depth must be a power of two (pointers wrap)
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [LEN_W-1:0]    LEN_MAX = {LEN_W{1'b1}};
  localparam logic [LIMIT_W-1:0]  BLOCK_LIMIT_RESET = LIMIT_W'(64);

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  // unit_id (index 0) and func_code (index 1) are tags only
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_LIMIT = 2'd2;

  typedef struct packed {
    logic                is_err;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic                last;
  } arg_token_t;

endpackage
`default_nettype wire

// ===== rtl/arg_front.sv =====
// Front end: insertion-sort chain, run counting and token streaming.
`default_nettype none
module arg_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [arg_pkg::ADDR_W-1:0]    address,
  input  wire logic                          last_address,
  input  wire logic [arg_pkg::LIMIT_W-1:0]   block_limit,
  output logic                               tok_valid,
  input  wire logic                          tok_ready,
  output arg_pkg::arg_token_t                tok
);
  import arg_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD   = 5'b00001,
    S_MARK   = 5'b00010,
    S_COUNT  = 5'b00100,
    S_STREAM = 5'b01000,
    S_ERR    = 5'b10000
  } front_state_t;

  front_state_t state;

  logic [ADDR_W-1:0]        cells [MAX_ADDRESSES];
  logic [CNT_W-1:0]         count;
  logic                     ovf;
  logic [MAX_ADDRESSES-1:0] bnd;
  logic [MAX_ADDRESSES-1:0] bnd_calc;
  logic [MAX_ADDRESSES-1:0] gt;
  logic [CNT_W-1:0]         runs;
  logic [CNT_W-1:0]         pos;
  logic [STATUS_W-1:0]      err_status;
  logic [LIMIT_W-1:0]       limit;

  logic in_fire, tok_fire, full, count_done, too_many, stream_last;

  assign in_ready    = (state == S_LOAD);
  assign in_fire     = in_valid && in_ready;
  assign tok_fire    = tok_valid && tok_ready;
  assign full        = (count == CNT_W'(MAX_ADDRESSES));
  assign count_done  = (pos >= count);
  assign stream_last = (pos == count - CNT_W'(1));
  assign limit       = (block_limit > LIMIT_W'(RESULT_CAP)) ? LIMIT_W'(RESULT_CAP) : block_limit;
  assign too_many    = (CMP_W'(runs) > CMP_W'(limit));

  // a cell is "greater" when empty or holding a larger address
  always_comb begin
    for (int i = 0; i < MAX_ADDRESSES; i++) begin
      gt[i] = (CNT_W'(i) >= count) || (cells[i] > address);
    end
  end

  // run boundary: entry does not continue the previous one by exactly +1
  always_comb begin
    bnd_calc[0] = 1'b0;
    for (int i = 1; i < MAX_ADDRESSES; i++) begin
      bnd_calc[i] = (CNT_W'(i) < count) &&
                    ({1'b0, cells[i]} != ({1'b0, cells[i-1]} + (ADDR_W+1)'(1)));
    end
  end

  for (genvar g = 0; g < MAX_ADDRESSES; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (state == S_LOAD && in_fire && !full && gt[g]) begin
        if (g == 0) begin
          cells[g] <= address;
        end else begin
          cells[g] <= gt[(g == 0) ? 0 : g-1] ? cells[(g == 0) ? 0 : g-1] : address;
        end
      end else if (state == S_STREAM && tok_fire && g < MAX_ADDRESSES-1) begin
        cells[g] <= cells[(g < MAX_ADDRESSES-1) ? g+1 : g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
            if (last_address) begin
              if (ovf || full) begin
                ovf   <= 1'b0;
                count <= '0;
                state <= S_ERR;
              end else begin
                state <= S_MARK;
              end
            end
          end
        end
        S_MARK: begin
          state <= S_COUNT;
        end
        S_COUNT: begin
          if (count_done) begin
            if (too_many) begin
              count <= '0;
              state <= S_ERR;
            end else begin
              state <= S_STREAM;
            end
          end
        end
        S_STREAM: begin
          if (tok_fire && stream_last) begin
            count <= '0;
            state <= S_LOAD;
          end
        end
        S_ERR: begin
          if (tok_fire) begin
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        if (in_fire && last_address) begin
          err_status <= ST_OVERFLOW;
        end
      end
      S_MARK: begin
        bnd  <= bnd_calc;
        runs <= CNT_W'(1);
        pos  <= CNT_W'(1);
      end
      S_COUNT: begin
        if (!count_done) begin
          runs <= runs + CNT_W'(bnd[1]);
          bnd  <= {1'b0, bnd[MAX_ADDRESSES-1:1]};
          pos  <= pos + CNT_W'(1);
        end else begin
          err_status <= ST_TOO_MANY;
          pos        <= '0;
        end
      end
      S_STREAM: begin
        if (tok_fire) begin
          pos <= pos + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    tok_valid  = (state == S_STREAM) || (state == S_ERR);
    tok.is_err = (state == S_ERR);
    tok.status = (state == S_ERR) ? err_status : ST_OK;
    tok.addr   = cells[0];
    tok.last   = (state == S_ERR) ? 1'b1 : stream_last;
  end

endmodule
`default_nettype wire

// ===== rtl/arg_fifo.sv =====
// Short token queue between the sorting front end and the run builder.
`default_nettype none
module arg_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_valid,
  output logic                     wr_ready,
  input  wire arg_pkg::arg_token_t wr_tok,
  output logic                     rd_valid,
  input  wire logic                rd_ready,
  output arg_pkg::arg_token_t      rd_tok
);
  import arg_pkg::*;

  arg_token_t         mem [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wptr;
  logic [Q_PTR_W-1:0] rptr;
  logic [Q_PTR_W:0]   fill;
  logic               wr_fire, rd_fire;

  assign wr_ready = (fill != (Q_PTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_tok   = mem[rptr];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr_fire) begin
        wptr <= wptr + Q_PTR_W'(1);
      end
      if (rd_fire) begin
        rptr <= rptr + Q_PTR_W'(1);
      end
      case ({wr_fire, rd_fire})
        2'b10:   fill <= fill + (Q_PTR_W+1)'(1);
        2'b01:   fill <= fill - (Q_PTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/arg_back.sv =====
// Back end: merges sorted addresses into runs and drives the result register.
`default_nettype none
module arg_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          tok_valid,
  output logic                               tok_ready,
  input  wire arg_pkg::arg_token_t           tok,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [arg_pkg::ADDR_W-1:0]         run_start,
  output logic [arg_pkg::LEN_W-1:0]          run_length,
  output logic [arg_pkg::STATUS_W-1:0]       status,
  output logic                               last_run
);
  import arg_pkg::*;

  logic                run_active;
  logic [ADDR_W-1:0]   acc_start;
  logic [LEN_W-1:0]    acc_len;
  logic [ADDR_W-1:0]   prev_addr;

  logic                run_active_next;
  logic [ADDR_W-1:0]   acc_start_next;
  logic [LEN_W-1:0]    acc_len_next;
  logic [ADDR_W-1:0]   prev_addr_next;

  logic                emit;
  logic [ADDR_W-1:0]   e_start;
  logic [LEN_W-1:0]    e_len;
  logic [STATUS_W-1:0] e_status;
  logic                e_last;

  logic slot, contiguous;
  logic [LEN_W-1:0] len_inc;

  assign slot       = !out_valid || out_ready;
  assign contiguous = run_active &&
                      ({1'b0, tok.addr} == ({1'b0, prev_addr} + (ADDR_W+1)'(1)));
  assign len_inc    = (acc_len == LEN_MAX) ? acc_len : acc_len + LEN_W'(1);

  always_comb begin
    emit            = 1'b0;
    tok_ready       = 1'b0;
    e_start         = acc_start;
    e_len           = acc_len;
    e_status        = ST_OK;
    e_last          = 1'b0;
    run_active_next = run_active;
    acc_start_next  = acc_start;
    acc_len_next    = acc_len;
    prev_addr_next  = prev_addr;
    if (tok_valid) begin
      if (tok.is_err) begin
        if (slot) begin
          emit      = 1'b1;
          tok_ready = 1'b1;
          e_start   = '0;
          e_len     = '0;
          e_status  = tok.status;
          e_last    = 1'b1;
        end
      end else if (run_active && !contiguous) begin
        // close the open run; the token is taken on a later cycle
        if (slot) begin
          emit            = 1'b1;
          run_active_next = 1'b0;
        end
      end else if (contiguous) begin
        if (tok.last) begin
          if (slot) begin
            emit            = 1'b1;
            tok_ready       = 1'b1;
            e_len           = len_inc;
            e_last          = 1'b1;
            run_active_next = 1'b0;
          end
        end else begin
          tok_ready      = 1'b1;
          acc_len_next   = len_inc;
          prev_addr_next = tok.addr;
        end
      end else begin
        if (tok.last) begin
          if (slot) begin
            emit      = 1'b1;
            tok_ready = 1'b1;
            e_start   = tok.addr;
            e_len     = LEN_W'(1);
            e_last    = 1'b1;
          end
        end else begin
          tok_ready       = 1'b1;
          run_active_next = 1'b1;
          acc_start_next  = tok.addr;
          acc_len_next    = LEN_W'(1);
          prev_addr_next  = tok.addr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      run_active <= 1'b0;
    end else begin
      run_active <= run_active_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_start <= acc_start_next;
    acc_len   <= acc_len_next;
    prev_addr <= prev_addr_next;
    if (emit) begin
      run_start  <= e_start;
      run_length <= e_len;
      status     <= e_status;
      last_run   <= e_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/address_run_grouper.sv =====
// Top level: address run grouper (sorter front end, token queue, run builder).
// Throughput: one address per cycle while a list loads. After the last address of a list
// the front end marks run boundaries, counts runs, then streams the sorted addresses
// (stalling on a full queue) before it loads again. A run is emitted once the address after
// it arrives, the final run with the last address; an overflow or too many runs gives one final error.
// Sync reset empties list, queue, result register, sets block_limit 64; chain not cleared.
`default_nettype none
module address_run_grouper (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [arg_pkg::REG_IDX_W-1:0]   cfg_index,
  input  wire logic [arg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [arg_pkg::ADDR_W-1:0]      address,
  input  wire logic                            last_address,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [arg_pkg::ADDR_W-1:0]           run_start,
  output logic [arg_pkg::LEN_W-1:0]            run_length,
  output logic [arg_pkg::STATUS_W-1:0]         status,
  output logic                                 last_run
);
  import arg_pkg::*;

  logic [LIMIT_W-1:0] block_limit;

  arg_token_t f_tok, q_tok;
  logic       f_valid, f_ready, q_valid, q_ready;

  // unit_id and func_code writes are accepted but nothing downstream reads them
  always_ff @(posedge clk) begin
    if (rst) begin
      block_limit <= BLOCK_LIMIT_RESET;
    end else if (cfg_write && cfg_index == REG_BLOCK_LIMIT) begin
      block_limit <= cfg_data[LIMIT_W-1:0];
    end
  end

  arg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .address      (address),
    .last_address (last_address),
    .block_limit  (block_limit),
    .tok_valid    (f_valid),
    .tok_ready    (f_ready),
    .tok          (f_tok)
  );

  arg_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_tok   (f_tok),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_tok   (q_tok)
  );

  arg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (q_valid),
    .tok_ready  (q_ready),
    .tok        (q_tok),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .run_start  (run_start),
    .run_length (run_length),
    .status     (status),
    .last_run   (last_run)
  );

endmodule
`default_nettype wire

// ===== rtl/arg_checker.sv =====
// Port-level checks for the address run grouper, bound to the top level.
`default_nettype none
module arg_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [arg_pkg::ADDR_W-1:0]      run_start,
  input  wire logic [arg_pkg::LEN_W-1:0]       run_length,
  input  wire logic [arg_pkg::STATUS_W-1:0]    status,
  input  wire logic                            last_run
);
  import arg_pkg::*;

  // error results are single, final and carry no run
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last_run && run_length == '0 && run_start == '0)
    else $error("error result with run data or not final");

  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> run_length != '0)
    else $error("ok result with zero length");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_TOO_MANY || status == ST_OVERFLOW)
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(run_start) && $stable(run_length)
                                && $stable(status) && $stable(last_run))
    else $error("stalled result changed");

endmodule

bind address_run_grouper arg_checker u_arg_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .run_start  (run_start),
  .run_length (run_length),
  .status     (status),
  .last_run   (last_run)
);
`default_nettype wire

// ===== tb/address_run_grouper_tb.sv =====
// Self-checking testbench for address_run_grouper: run prediction and item-level checks.

typedef struct packed {
  logic [arg_pkg::ADDR_W-1:0]   start;
  logic [arg_pkg::LEN_W-1:0]    length;
  logic [arg_pkg::STATUS_W-1:0] code;
  logic                         final_run;
} run_result_t;

class address_run_tracker;
  logic [arg_pkg::ADDR_W-1:0]  store [arg_pkg::MAX_ADDRESSES];
  int                          loaded;
  bit                          overflowed;
  logic [arg_pkg::LIMIT_W-1:0] limit_reg;
  run_result_t                 expected_runs[$];
  int                          mismatches;

  function new();
    loaded = 0;
    overflowed = 1'b0;
    limit_reg = arg_pkg::BLOCK_LIMIT_RESET;
    mismatches = 0;
  endfunction

  // unit and function-code tags never change a result
  function void set_register(logic [arg_pkg::REG_IDX_W-1:0] idx,
                             logic [arg_pkg::CFG_DATA_W-1:0] data);
    if (idx == arg_pkg::REG_BLOCK_LIMIT) begin
      limit_reg = data[arg_pkg::LIMIT_W-1:0];
    end
  endfunction

  function run_result_t make_run(int start, int len, logic [arg_pkg::STATUS_W-1:0] code,
                                 logic final_run);
    run_result_t r;
    r.start = start[arg_pkg::ADDR_W-1:0];
    r.length = (len > 127) ? 7'd127 : len[arg_pkg::LEN_W-1:0];
    r.code = code;
    r.final_run = final_run;
    return r;
  endfunction

  function void take_address(logic [arg_pkg::ADDR_W-1:0] a, logic last);
    run_result_t found[$];
    logic [arg_pkg::ADDR_W-1:0] v;
    int n, i, j, len, lim, start;
    if (loaded < arg_pkg::MAX_ADDRESSES) begin
      store[loaded] = a;
      loaded++;
    end else begin
      overflowed = 1'b1;
    end
    if (!last) return;
    n = loaded;
    loaded = 0;
    if (overflowed) begin
      overflowed = 1'b0;
      expected_runs.push_back(make_run(0, 0, arg_pkg::ST_OVERFLOW, 1'b1));
      return;
    end
    for (i = 1; i < n; i++) begin
      v = store[i];
      j = i;
      while (j > 0 && store[j-1] > v) begin
        store[j] = store[j-1];
        j--;
      end
      store[j] = v;
    end
    // 16'hFFFF followed by 0 is not consecutive: compare as int
    start = int'(store[0]);
    len = 1;
    for (i = 1; i < n; i++) begin
      if (int'(store[i]) == int'(store[i-1]) + 1) begin
        len++;
      end else begin
        found.push_back(make_run(start, len, arg_pkg::ST_OK, 1'b0));
        start = int'(store[i]);
        len = 1;
      end
    end
    found.push_back(make_run(start, len, arg_pkg::ST_OK, 1'b1));
    lim = (int'(limit_reg) > arg_pkg::RESULT_CAP) ? arg_pkg::RESULT_CAP : int'(limit_reg);
    if (found.size() > lim) begin
      expected_runs.push_back(make_run(0, 0, arg_pkg::ST_TOO_MANY, 1'b1));
    end else begin
      foreach (found[k]) expected_runs.push_back(found[k]);
    end
  endfunction

  function void check_run(run_result_t got);
    run_result_t want;
    if (expected_runs.size() == 0) begin
      $display("%0t: unexpected item: expected none, got start %h len %0d status %0d last %0b",
               $time, got.start, got.length, got.code, got.final_run);
      mismatches++;
      return;
    end
    want = expected_runs.pop_front();
    if (got.start != want.start) begin
      $display("%0t: run_start expected %h got %h", $time, want.start, got.start);
      mismatches++;
    end
    if (got.length != want.length) begin
      $display("%0t: run_length expected %0d got %0d", $time, want.length, got.length);
      mismatches++;
    end
    if (got.code != want.code) begin
      $display("%0t: status expected %0d got %0d", $time, want.code, got.code);
      mismatches++;
    end
    if (got.final_run !== want.final_run) begin
      $display("%0t: last_run expected %0b got %0b", $time, want.final_run, got.final_run);
      mismatches++;
    end
  endfunction
endclass

module address_run_grouper_tb;
  import arg_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNIT_ID   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FUNC_CODE = 2'd1;
  localparam int SETTLE_CYCLES = 2 * MAX_ADDRESSES + 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 300000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ADDR_W-1:0]     address = '0;
  logic                  last_address = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ADDR_W-1:0]     run_start;
  logic [LEN_W-1:0]      run_length;
  logic [STATUS_W-1:0]   status;
  logic                  last_run;

  int send_idle_pct = 21;
  int recv_idle_pct = 72;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycles = 0;

  address_run_tracker tracker = new();

  address_run_grouper u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .address(address), .last_address(last_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .run_start(run_start), .run_length(run_length), .status(status), .last_run(last_run)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // inputs noted before results so a list is predicted before its runs show up
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.take_address(address, last_address);
      if (out_valid && out_ready)
        tracker.check_run(run_result_t'{run_start, run_length, status, last_run});
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_address(input logic [ADDR_W-1:0] a, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    address <= a;
    last_address <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // mostly runs of consecutive addresses with duplicates, shuffled; some pure noise
  task automatic send_list(input int n);
    logic [ADDR_W-1:0] addrs[$];
    logic [ADDR_W-1:0] base, tmp;
    int run_len, j, k;
    bit noise;
    noise = ($urandom_range(0, 4) == 0);
    while (addrs.size() < n) begin
      if (noise) begin
        addrs.push_back(ADDR_W'($urandom()));
      end else begin
        case ($urandom_range(0, 5))
          0: base = ADDR_W'($urandom_range(65530, 65535));
          1: base = ADDR_W'($urandom_range(0, 5));
          default: base = ADDR_W'($urandom());
        endcase
        run_len = $urandom_range(1, 6);
        for (k = 0; k < run_len && addrs.size() < n; k++) begin
          addrs.push_back(base + ADDR_W'(k));
          if ($urandom_range(0, 7) == 0 && addrs.size() < n) addrs.push_back(base + ADDR_W'(k));
        end
      end
    end
    for (k = n - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = addrs[k];
      addrs[k] = addrs[j];
      addrs[j] = tmp;
    end
    for (k = 0; k < n; k++) send_address(addrs[k], k == n - 1);
  endtask

  task automatic run_random(input int budget, input int max_len);
    int sent, n;
    sent = 0;
    while (sent < budget) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, max_len);
      send_list(n);
      sent += n;
    end
  endtask

  task automatic configure(input logic [7:0] unit, input logic [7:0] func,
                           input logic [7:0] limit);
    cfg_write <= 1'b1;
    cfg_index <= REG_UNIT_ID;
    cfg_data <= unit;
    tracker.set_register(REG_UNIT_ID, unit);
    @(negedge clk);
    cfg_index <= REG_FUNC_CODE;
    cfg_data <= func;
    tracker.set_register(REG_FUNC_CODE, func);
    @(negedge clk);
    cfg_index <= REG_BLOCK_LIMIT;
    cfg_data <= limit;
    tracker.set_register(REG_BLOCK_LIMIT, limit);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.expected_runs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: limit 64
    send_address(16'h0000, 1'b1);
    send_address(16'hFFFF, 1'b0);
    send_address(16'h0000, 1'b1);
    send_address(16'h0007, 1'b0);
    send_address(16'h0005, 1'b0);
    send_address(16'h0006, 1'b0);
    send_address(16'h0005, 1'b1);
    send_address(16'hFFFE, 1'b0);
    send_address(16'hFFFF, 1'b0);
    send_address(16'h7FFF, 1'b0);
    send_address(16'h8000, 1'b0);
    send_address(16'h5555, 1'b0);
    send_address(16'hAAAA, 1'b1);
    run_random(15, 10);
    drain();

    // limit 0: every list is rejected
    configure(8'h00, 8'h00, 8'd0);
    send_address(16'h1234, 1'b1);
    run_random(8, 6);
    drain();

    send_idle_pct = 72;
    recv_idle_pct = 21;
    configure(8'hFF, 8'hFF, 8'd1);
    send_address(16'h0003, 1'b0);
    send_address(16'h0002, 1'b1);
    send_address(16'h0003, 1'b0);
    send_address(16'h0005, 1'b1);
    run_random(12, 3);
    drain();

    // limit field all ones saturates at 64; long lists under a long receiver stall
    configure(8'($urandom()), 8'($urandom()), 8'hFF);
    hold_requests = hold_requests + 1;
    send_list(MAX_ADDRESSES);
    send_list(MAX_ADDRESSES + 1);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(8'($urandom()), 8'($urandom()), 8'($urandom_range(2, 8)));
    run_random(12, 12);
    drain();

    configure(8'($urandom()), 8'($urandom()), 8'd64);
    run_random(12, 12);
    drain();

    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
